// ===== rtl/dvpt_pkg.sv =====
package dvpt_pkg;

    // One viewport rectangle, all fields unsigned Q14.2 pixels.
    typedef struct packed {
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] w;
        logic [15:0] h;
    } rect_t;

    // Saturation value of the pass counters.
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Tolerance after reset, in quarter pixels.
    localparam logic [15:0] TOLERANCE_RESET = 16'd32;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic  copy_now;
        rect_t copy_rect;
        logic  world_valid;
        rect_t world_rect;
    } result_t;

endpackage

// ===== rtl/dominant_viewport_pass_tally.sv =====
// Dominant viewport pass tally. Each item is one render pass (frame tag and viewport
// rectangle); each accepted item gives exactly one result item. Passes whose rectangle lies
// within match_tolerance of a stored group are counted into that group; match_tolerance is to be
// written on the cfg port only while the block is idle, and the block itself does not enforce
// this. When the frame tag changes, the most-used group of the frame that ended becomes the
// copy target, and the result flags the pass on which to copy it.
// Timing: the block works on one item at a time and walks the group table one slot per
// cycle through a single shared rectangle comparator. After acceptance, an item is compared
// with each used slot in turn, then the finishing step inserts it, checks for the copy pass
// and registers the result; the next item is taken once the block is back in idle. An item
// that starts a new frame first walks the old table and settles the copy target, then meets
// an empty table. The last step waits while an earlier result is still held in the output
// register; otherwise the next item is taken while a finished result waits there.
module dominant_viewport_pass_tally #(
    parameter int GROUP_SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel (match tolerance).
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input item channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_frame_tag,
    input  logic [15:0] s_view_left,
    input  logic [15:0] s_view_top,
    input  logic [15:0] s_view_width,
    input  logic [15:0] s_view_height,
    // Result item channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_copy_now,
    output logic [15:0] m_copy_left,
    output logic [15:0] m_copy_top,
    output logic [15:0] m_copy_width,
    output logic [15:0] m_copy_height,
    output logic        m_world_valid,
    output logic [15:0] m_world_left,
    output logic [15:0] m_world_top,
    output logic [15:0] m_world_width,
    output logic [15:0] m_world_height
);

    localparam int CNT_W = $clog2(GROUP_SLOTS + 1);
    localparam int IDX_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(GROUP_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL_SCAN,
        ST_ROLL_FIN,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [15:0]           tolerance_reg;
    logic [15:0]           frame_tag_reg;
    logic [15:0]           item_tag_reg;
    dvpt_pkg::rect_t       item_rect_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      scan_reg;
    logic                  found_reg;
    logic                  best_valid_reg;
    dvpt_pkg::rect_t       best_rect_reg;
    logic [15:0]           best_cnt_reg;
    logic                  prior_valid_reg;
    dvpt_pkg::rect_t       prior_rect_reg;
    logic [15:0]           prior_passes_reg;
    dvpt_pkg::rect_t       target_rect_reg;
    logic [15:0]           target_pass_reg;
    logic [15:0]           seen_reg;
    logic                  m_valid_reg;
    dvpt_pkg::result_t     result_reg;

    // Group table: one read port at the scan slot, one write port.
    dvpt_pkg::rect_t       group_rect_mem [GROUP_SLOTS];
    logic [15:0]           group_cnt_mem  [GROUP_SLOTS];

    logic [IDX_W-1:0]      scan_idx;
    logic [IDX_W-1:0]      used_idx;
    dvpt_pkg::rect_t       slot_rect;
    logic [15:0]           slot_cnt;

    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign used_idx  = used_reg[IDX_W-1:0];
    assign slot_rect = group_rect_mem[scan_idx];
    assign slot_cnt  = group_cnt_mem[scan_idx];

    // Shared rectangle comparator; its operands depend on the sequencer step.
    dvpt_pkg::rect_t cmp_a;
    dvpt_pkg::rect_t cmp_b;
    logic            cmp_same;

    function automatic logic near16(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] tol);
        logic [15:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

    always_comb begin
        unique case (state_reg)
            ST_ROLL_FIN: begin
                cmp_a = best_rect_reg;
                cmp_b = prior_rect_reg;
            end
            ST_FINISH: begin
                cmp_a = target_rect_reg;
                cmp_b = item_rect_reg;
            end
            default: begin
                cmp_a = slot_rect;
                cmp_b = item_rect_reg;
            end
        endcase
        cmp_same = near16(cmp_a.l, cmp_b.l, tolerance_reg)
                && near16(cmp_a.t, cmp_b.t, tolerance_reg)
                && near16(cmp_a.w, cmp_b.w, tolerance_reg)
                && near16(cmp_a.h, cmp_b.h, tolerance_reg);
    end

    // Scan step: the first matching slot is counted and widened; best tracks updated values.
    logic            scan_done;
    logic            first_hit;
    logic [15:0]     eff_cnt;
    dvpt_pkg::rect_t eff_rect;

    always_comb begin
        scan_done = (scan_reg == used_reg);
        first_hit = cmp_same && !found_reg;
        eff_rect  = slot_rect;
        eff_cnt   = slot_cnt;
        if (first_hit) begin
            if (slot_cnt != dvpt_pkg::COUNT_MAX) begin
                eff_cnt = slot_cnt + 16'd1;
            end
            if (item_rect_reg.w > slot_rect.w) begin
                eff_rect.w = item_rect_reg.w;
            end
            if (item_rect_reg.h > slot_rect.h) begin
                eff_rect.h = item_rect_reg.h;
            end
        end
    end

    // Finishing step: insertion of an unmatched rectangle, copy check and the result.
    logic              insert;
    logic              copy_hit;
    logic [15:0]       seen_inc;
    logic              world_valid;
    dvpt_pkg::rect_t   world_rect;
    dvpt_pkg::result_t result_next;
    logic              out_free;

    always_comb begin
        insert      = !found_reg && (used_reg < SLOTS_C);
        copy_hit    = (target_pass_reg != 16'd0) && cmp_same
                   && (seen_reg != dvpt_pkg::COUNT_MAX);
        seen_inc    = seen_reg + 16'd1;
        world_valid = best_valid_reg || insert;
        world_rect  = best_valid_reg ? best_rect_reg : item_rect_reg;
        result_next.copy_now    = copy_hit && (seen_inc == target_pass_reg);
        result_next.copy_rect   = result_next.copy_now ? target_rect_reg : '0;
        result_next.world_valid = world_valid;
        result_next.world_rect  = world_valid ? world_rect : '0;
        out_free    = !m_valid_reg || m_ready;
    end

    // Roll step: the copy count is the smaller of the two frames' counts when groups match.
    logic [15:0] roll_target;

    always_comb begin
        roll_target = best_cnt_reg;
        if (prior_valid_reg && cmp_same && (prior_passes_reg < best_cnt_reg)) begin
            roll_target = prior_passes_reg;
        end
    end

    // Group table writes.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && !scan_done && first_hit) begin
            group_rect_mem[scan_idx] <= eff_rect;
            group_cnt_mem[scan_idx]  <= eff_cnt;
        end else if (state_reg == ST_FINISH && out_free && insert) begin
            group_rect_mem[used_idx] <= item_rect_reg;
            group_cnt_mem[used_idx]  <= 16'd1;
        end
    end

    // Sequencer and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tolerance_reg    <= dvpt_pkg::TOLERANCE_RESET;
            frame_tag_reg    <= '0;
            used_reg         <= '0;
            scan_reg         <= '0;
            found_reg        <= 1'b0;
            best_valid_reg   <= 1'b0;
            prior_valid_reg  <= 1'b0;
            prior_rect_reg   <= '0;
            prior_passes_reg <= '0;
            target_rect_reg  <= '0;
            target_pass_reg  <= '0;
            seen_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tolerance_reg <= cfg_data;
            end
            // The finishing step reloads the output register itself.
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_tag_reg   <= s_frame_tag;
                        item_rect_reg  <= '{l: s_view_left, t: s_view_top,
                                           w: s_view_width, h: s_view_height};
                        scan_reg       <= '0;
                        found_reg      <= 1'b0;
                        best_valid_reg <= 1'b0;
                        state_reg      <= (s_frame_tag != frame_tag_reg) ? ST_ROLL_SCAN
                                                                         : ST_SCAN;
                    end
                end

                // Find the first most-used group of the frame that ends.
                ST_ROLL_SCAN: begin
                    if (scan_done) begin
                        state_reg <= ST_ROLL_FIN;
                    end else begin
                        if (!best_valid_reg || slot_cnt > best_cnt_reg) begin
                            best_valid_reg <= 1'b1;
                            best_rect_reg  <= slot_rect;
                            best_cnt_reg   <= slot_cnt;
                        end
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end

                // Settle the copy target and open the new frame.
                ST_ROLL_FIN: begin
                    if (best_valid_reg) begin
                        target_pass_reg  <= roll_target;
                        target_rect_reg  <= best_rect_reg;
                        prior_valid_reg  <= 1'b1;
                        prior_rect_reg   <= best_rect_reg;
                        prior_passes_reg <= best_cnt_reg;
                    end else begin
                        target_pass_reg  <= '0;
                        target_rect_reg  <= '0;
                        prior_valid_reg  <= 1'b0;
                        prior_rect_reg   <= '0;
                        prior_passes_reg <= '0;
                    end
                    frame_tag_reg  <= item_tag_reg;
                    used_reg       <= '0;
                    seen_reg       <= '0;
                    scan_reg       <= '0;
                    best_valid_reg <= 1'b0;
                    state_reg      <= ST_SCAN;
                end

                // Match the item against each group and track the most-used one.
                ST_SCAN: begin
                    if (scan_done) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        if (first_hit) begin
                            found_reg <= 1'b1;
                        end
                        if (!best_valid_reg || eff_cnt > best_cnt_reg) begin
                            best_valid_reg <= 1'b1;
                            best_rect_reg  <= eff_rect;
                            best_cnt_reg   <= eff_cnt;
                        end
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end

                // Insert, check for the copy pass and hand the result over.
                ST_FINISH: begin
                    if (out_free) begin
                        if (insert) begin
                            used_reg <= used_reg + CNT_W'(1);
                        end
                        if (copy_hit) begin
                            seen_reg <= seen_inc;
                        end
                        result_reg  <= result_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_copy_now     = result_reg.copy_now;
    assign m_copy_left    = result_reg.copy_rect.l;
    assign m_copy_top     = result_reg.copy_rect.t;
    assign m_copy_width   = result_reg.copy_rect.w;
    assign m_copy_height  = result_reg.copy_rect.h;
    assign m_world_valid  = result_reg.world_valid;
    assign m_world_left   = result_reg.world_rect.l;
    assign m_world_top    = result_reg.world_rect.t;
    assign m_world_width  = result_reg.world_rect.w;
    assign m_world_height = result_reg.world_rect.h;

endmodule

// ===== tb/tb_dominant_viewport_pass_tally.sv =====
module tb_dominant_viewport_pass_tally;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_frame_tag = '0;
    logic [15:0] s_view_left = '0;
    logic [15:0] s_view_top = '0;
    logic [15:0] s_view_width = '0;
    logic [15:0] s_view_height = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_copy_now;
    logic [15:0] m_copy_left;
    logic [15:0] m_copy_top;
    logic [15:0] m_copy_width;
    logic [15:0] m_copy_height;
    logic        m_world_valid;
    logic [15:0] m_world_left;
    logic [15:0] m_world_top;
    logic [15:0] m_world_width;
    logic [15:0] m_world_height;

    dominant_viewport_pass_tally #(
        .GROUP_SLOTS(SLOTS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_tag   (s_frame_tag),
        .s_view_left   (s_view_left),
        .s_view_top    (s_view_top),
        .s_view_width  (s_view_width),
        .s_view_height (s_view_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_copy_now    (m_copy_now),
        .m_copy_left   (m_copy_left),
        .m_copy_top    (m_copy_top),
        .m_copy_width  (m_copy_width),
        .m_copy_height (m_copy_height),
        .m_world_valid (m_world_valid),
        .m_world_left  (m_world_left),
        .m_world_top   (m_world_top),
        .m_world_width (m_world_width),
        .m_world_height(m_world_height)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the tally state, kept in step with accepted items.
    logic [15:0]       cur_tolerance = dvpt_pkg::TOLERANCE_RESET;
    logic [15:0]       cur_tag = '0;
    dvpt_pkg::rect_t   grp_rect [SLOTS];
    logic [15:0]       grp_count [SLOTS];
    int                grp_used = 0;
    bit                last_valid = 1'b0;
    dvpt_pkg::rect_t   last_rect = '0;
    logic [15:0]       last_count = '0;
    dvpt_pkg::rect_t   copy_target = '0;
    logic [15:0]       copy_at = '0;
    logic [15:0]       target_hits = '0;

    dvpt_pkg::result_t expected_results [$];
    dvpt_pkg::result_t oldest;
    int                errors = 0;
    int                items_sent = 0;
    int                frames_closed = 0;
    int                copies_due = 0;

    // Sender burst state and receiver stall pattern.
    int          burst_left = 0;
    logic [15:0] stall_pat = '1;
    logic [5:0]  stall_ptr = '0;

    function automatic bit near_enough(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = (a > b) ? a - b : b - a;
        return d <= cur_tolerance;
    endfunction

    function automatic bit same_view(dvpt_pkg::rect_t a, dvpt_pkg::rect_t b);
        return near_enough(a.l, b.l) && near_enough(a.t, b.t) &&
               near_enough(a.w, b.w) && near_enough(a.h, b.h);
    endfunction

    // First slot with the highest pass count, or -1 for an empty table.
    function automatic int busiest_group();
        int best;
        best = -1;
        for (int i = 0; i < grp_used; i++) begin
            if (best < 0 || grp_count[i] > grp_count[best])
                best = i;
        end
        return best;
    endfunction

    // A new tag settles the copy target from the frame that just ended.
    function automatic void close_frame(logic [15:0] tag);
        int          f;
        logic [15:0] n;
        f = busiest_group();
        frames_closed++;
        if (f < 0) begin
            copy_at = '0;
            copy_target = '0;
            last_valid = 1'b0;
            last_rect = '0;
            last_count = '0;
        end else begin
            n = grp_count[f];
            if (last_valid && same_view(grp_rect[f], last_rect) && last_count < n)
                n = last_count;
            copy_at = n;
            copy_target = grp_rect[f];
            last_valid = 1'b1;
            last_rect = grp_rect[f];
            last_count = grp_count[f];
        end
        cur_tag = tag;
        grp_used = 0;
        target_hits = '0;
    endfunction

    function automatic dvpt_pkg::result_t predict_pass(logic [15:0] tag, dvpt_pkg::rect_t v);
        dvpt_pkg::result_t r;
        bit                hit;
        int                slot;
        if (tag != cur_tag)
            close_frame(tag);
        // Count the pass into the first matching group, or open a new one.
        hit = 1'b0;
        for (int i = 0; i < grp_used; i++) begin
            if (!hit && same_view(grp_rect[i], v)) begin
                if (grp_count[i] != dvpt_pkg::COUNT_MAX)
                    grp_count[i] = grp_count[i] + 16'd1;
                if (v.w > grp_rect[i].w)
                    grp_rect[i].w = v.w;
                if (v.h > grp_rect[i].h)
                    grp_rect[i].h = v.h;
                hit = 1'b1;
            end
        end
        if (!hit && grp_used < SLOTS) begin
            grp_rect[grp_used] = v;
            grp_count[grp_used] = 16'd1;
            grp_used++;
        end
        // Passes that match the target count toward the copy pass.
        r = '0;
        if (copy_at != 0 && same_view(copy_target, v) && target_hits != dvpt_pkg::COUNT_MAX)
        begin
            target_hits = target_hits + 16'd1;
            if (target_hits == copy_at) begin
                r.copy_now = 1'b1;
                r.copy_rect = copy_target;
                copies_due++;
            end
        end
        slot = busiest_group();
        if (slot >= 0) begin
            r.world_valid = 1'b1;
            r.world_rect = grp_rect[slot];
        end
        return r;
    endfunction

    function automatic dvpt_pkg::rect_t view(logic [15:0] l, logic [15:0] t, logic [15:0] w,
                                             logic [15:0] h);
        dvpt_pkg::rect_t r;
        r.l = l;
        r.t = t;
        r.w = w;
        r.h = h;
        return r;
    endfunction

    // Random field values, with the two extremes showing up often.
    function automatic logic [15:0] random_field();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 16'h0000;
        else if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic dvpt_pkg::rect_t random_view();
        return view(random_field(), random_field(), random_field(), random_field());
    endfunction

    function automatic logic [15:0] nudge(logic [15:0] x, int span);
        int v;
        v = int'(x) + $urandom_range(0, 2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // A rectangle near the base one, within the current tolerance on every field.
    function automatic dvpt_pkg::rect_t jitter_view(dvpt_pkg::rect_t base);
        int span;
        span = (cur_tolerance < 24) ? int'(cur_tolerance) : 24;
        return view(nudge(base.l, span), nudge(base.t, span), nudge(base.w, span),
                    nudge(base.h, span));
    endfunction

    // Sends one pass; valid stays high across a burst and drops only for a gap.
    task automatic send_pass(input logic [15:0] tag, input dvpt_pkg::rect_t v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_frame_tag <= tag;
        s_view_left <= v.l;
        s_view_top <= v.t;
        s_view_width <= v.w;
        s_view_height <= v.h;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_pass(tag, v));
        items_sent++;
    endtask

    // Waits until every result has come back and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_tolerance = value;
    endtask

    // Grouping, ties, a full table, tolerance edges and copy passes at the reset tolerance.
    task automatic test_grouping_basics();
        send_pass(16'h0000, view(16'd100, 16'd100, 16'd200, 16'd200));
        send_pass(16'h0000, view(16'd110, 16'd90, 16'd220, 16'd190));
        send_pass(16'h0000, view(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pass(16'h0000, view(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pass(16'h0000, view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pass(16'h0000, view(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // The table is full here, so this one lands in no group.
        send_pass(16'h0000, view(16'h4000, 16'h4000, 16'h4000, 16'h4000));
        send_pass(16'h0001, view(16'd100, 16'd100, 16'd220, 16'd200));
        // Exactly at the tolerance on every field, then one quarter pixel past it on the left field.
        send_pass(16'h0001, view(16'd132, 16'd68, 16'd252, 16'd232));
        send_pass(16'h0001, view(16'd133, 16'd100, 16'd220, 16'd200));
        send_pass(16'h0002, view(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_pass(16'h0002, view(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_pass(16'h0002, view(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_pass(16'h0003, view(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_pass(16'h0003, view(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_pass(16'hFFFF, view(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_pass(16'h0000, view(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        send_pass(16'h0000, view(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    endtask

    // Frames drawn from a small set of scene rectangles, with noise passes mixed in.
    task automatic test_random_frames(input logic [15:0] tol, input int count);
        dvpt_pkg::rect_t scene [5];
        int              n_scene;
        int              frames_left;
        int              passes;
        int              pick;
        logic [15:0]     tag;
        write_tolerance(tol);
        n_scene = 1;
        frames_left = 0;
        tag = cur_tag;
        for (int sent = 0; sent < count; ) begin
            if (frames_left == 0) begin
                n_scene = $urandom_range(1, 5);
                for (int i = 0; i < n_scene; i++)
                    scene[i] = random_view();
                frames_left = $urandom_range(3, 6);
            end
            frames_left--;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                tag = tag + 16'd1;
            else if (pick < 9)
                tag = 16'($urandom);
            passes = $urandom_range(1, 12);
            for (int p = 0; p < passes; p++) begin
                if ($urandom_range(0, 99) < 15)
                    send_pass(tag, random_view());
                else if ($urandom_range(0, 1) == 0)
                    send_pass(tag, jitter_view(scene[0]));
                else
                    send_pass(tag, jitter_view(scene[$urandom_range(0, n_scene - 1)]));
            end
            sent += passes;
        end
    endtask

    // Receiver ready follows a repeating 16-bit pattern that is redrawn each time the 6-bit pointer wraps.
    always @(posedge aclk) begin
        if (stall_ptr == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat <= '1;
                1: stall_pat <= 16'($urandom & $urandom);
                default: stall_pat <= 16'($urandom | $urandom);
            endcase
        end
        m_ready <= stall_pat[stall_ptr[3:0]];
        stall_ptr <= stall_ptr + 6'd1;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Each accepted result item is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                errors++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("copy_now", 16'(oldest.copy_now), 16'(m_copy_now));
                check_field("copy_left", oldest.copy_rect.l, m_copy_left);
                check_field("copy_top", oldest.copy_rect.t, m_copy_top);
                check_field("copy_width", oldest.copy_rect.w, m_copy_width);
                check_field("copy_height", oldest.copy_rect.h, m_copy_height);
                check_field("world_valid", 16'(oldest.world_valid), 16'(m_world_valid));
                check_field("world_left", oldest.world_rect.l, m_world_left);
                check_field("world_top", oldest.world_rect.t, m_world_top);
                check_field("world_width", oldest.world_rect.w, m_world_width);
                check_field("world_height", oldest.world_rect.h, m_world_height);
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_grouping_basics();
        test_random_frames(16'd0, 310);
        test_random_frames(16'hFFFF, 310);
        test_random_frames(16'($urandom_range(1, 300)), 310);
        test_random_frames(dvpt_pkg::TOLERANCE_RESET, 310);
        test_random_frames(16'($urandom), 310);
        settle();
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result items never arrived", expected_results.size());
            errors++;
        end
        $display("Sent %0d passes over %0d frame changes; %0d of them were copy passes.",
                 items_sent, frames_closed, copies_due);
        $display("Tolerance ran at reset, zero, full scale and random values.");
        if (errors == 0) begin
            $display("dominant_viewport_pass_tally: match");
        end else begin
            $display("dominant_viewport_pass_tally: mismatch");
        end
        $finish;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #100ms;
        $display("dominant_viewport_pass_tally: mismatch");
        $finish;
    end

endmodule
